// ===== design/bfr_pkg.sv =====
`timescale 1ns / 1ps

package bfr_pkg;

    localparam int MAX_FRAME_LEN_DEF = 120;
    localparam int BYTE_W            = 8;
    localparam int CFG_IDX_W         = 3;
    localparam int PLEN_W            = 7;
    localparam int SUM_W             = 16;

    localparam logic [BYTE_W-1:0] ACK_CODE_RST   = 8'd6;
    localparam logic [BYTE_W-1:0] NAK_CODE_RST   = 8'd21;
    localparam logic [BYTE_W-1:0] MAX_ERRORS_RST = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_FIRST     = 3'd0,
        REG_SYNC_SECOND    = 3'd1,
        REG_SYNC_THIRD     = 3'd2,
        REG_USE_ADDRESS    = 3'd3,
        REG_DEVICE_ADDRESS = 3'd4,
        REG_ACK_CODE       = 3'd5,
        REG_NAK_CODE       = 3'd6,
        REG_MAX_ERRORS     = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_NAK     = 2'd2,
        KIND_GIVE_UP = 2'd3
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] sync_third;
        logic              use_address;
        logic [BYTE_W-1:0] device_address;
        logic [BYTE_W-1:0] ack_code;
        logic [BYTE_W-1:0] nak_code;
        logic [BYTE_W-1:0] max_errors;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] reply_code;
        logic [PLEN_W-1:0] payload_length;
    } t_result;

endpackage

// ===== design/bfr_in_if.sv =====
`timescale 1ns / 1ps

interface bfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/bfr_out_if.sv =====
`timescale 1ns / 1ps

interface bfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] reply_code;
    logic [6:0] payload_length;

    modport source (output valid, output kind, output value, output reply_code,
                    output payload_length, input ready);
    modport sink   (input valid, input kind, input value, input reply_code,
                    input payload_length, output ready);
endinterface

// ===== design/binary_frame_receiver.sv =====
`timescale 1ns / 1ps

// Byte-stream frame receiver. One byte is taken per clock cycle with no gaps
// needed: each byte is checked and folded into the frame state by combinational
// compare and 16-bit add logic, and any result (payload byte, ACK, NAK or
// give-up) appears in the output register on the next cycle. The input stays
// ready while the output register is empty or being drained, so throughput is
// one byte per cycle whenever the sink takes results. Configuration writes
// take effect on the following cycle and belong between frames.
module binary_frame_receiver import bfr_pkg::*; #(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    bfr_in_if.sink               i_rx,
    bfr_out_if.source            o_res
);

    t_cfg    cfg;
    logic    space;
    logic    accept;
    logic    res_valid;
    t_result res;

    assign i_rx.ready = space;
    assign accept     = i_rx.valid && space;

    bfr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bfr_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bfr_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_space     (space),
        .o_res       (o_res)
    );

endmodule

// ===== design/bfr_cfg_regs.sv =====
`timescale 1ns / 1ps

module bfr_cfg_regs import bfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_SYNC_FIRST:     n_cfg.sync_first     = i_cfg_data;
                REG_SYNC_SECOND:    n_cfg.sync_second    = i_cfg_data;
                REG_SYNC_THIRD:     n_cfg.sync_third     = i_cfg_data;
                REG_USE_ADDRESS:    n_cfg.use_address    = i_cfg_data[0];
                REG_DEVICE_ADDRESS: n_cfg.device_address = i_cfg_data;
                REG_ACK_CODE:       n_cfg.ack_code       = i_cfg_data;
                REG_NAK_CODE:       n_cfg.nak_code       = i_cfg_data;
                REG_MAX_ERRORS:     n_cfg.max_errors     = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first     <= '0;
            r_cfg.sync_second    <= '0;
            r_cfg.sync_third     <= '0;
            r_cfg.use_address    <= 1'b0;
            r_cfg.device_address <= '0;
            r_cfg.ack_code       <= ACK_CODE_RST;
            r_cfg.nak_code       <= NAK_CODE_RST;
            r_cfg.max_errors     <= MAX_ERRORS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/bfr_parser.sv =====
`timescale 1ns / 1ps

module bfr_parser import bfr_pkg::*; #(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam int LEN_W = $clog2(MAX_FRAME_LEN + 1);
    localparam int POS_W = $clog2(MAX_FRAME_LEN);

    logic              r_in_body;
    logic [POS_W-1:0]  r_position;
    logic              r_header_bad;
    logic [LEN_W-1:0]  r_frame_length;
    logic [SUM_W-1:0]  r_running_sum;
    logic [BYTE_W-1:0] r_sum_high_byte;
    logic [BYTE_W-1:0] r_error_count;

    logic              n_in_body;
    logic [POS_W-1:0]  n_position;
    logic              n_header_bad;
    logic [LEN_W-1:0]  n_frame_length;
    logic [SUM_W-1:0]  n_running_sum;
    logic [BYTE_W-1:0] n_sum_high_byte;
    logic [BYTE_W-1:0] n_error_count;

    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  pos_ext;
    logic [BYTE_W:0]   err_next;
    logic              give_up;
    logic              len_bad;
    logic              sum_ok;
    logic [BYTE_W-1:0] want_third;
    logic              do_fail;
    logic [BYTE_W-1:0] fail_echo;

    assign plen       = r_frame_length - LEN_W'(2);
    assign pos_ext    = LEN_W'(r_position);
    assign err_next   = {1'b0, r_error_count} + (BYTE_W+1)'(1);
    assign give_up    = err_next >= {1'b0, i_cfg.max_errors};
    assign len_bad    = (i_byte > BYTE_W'(MAX_FRAME_LEN)) || (i_byte < BYTE_W'(2));
    assign sum_ok     = (r_sum_high_byte == r_running_sum[SUM_W-1:BYTE_W]) &&
                        (i_byte == r_running_sum[BYTE_W-1:0]);
    assign want_third = i_cfg.use_address ? i_cfg.device_address : i_cfg.sync_third;

    always_comb begin
        n_in_body       = r_in_body;
        n_position      = r_position;
        n_header_bad    = r_header_bad;
        n_frame_length  = r_frame_length;
        n_running_sum   = r_running_sum;
        n_sum_high_byte = r_sum_high_byte;
        n_error_count   = r_error_count;
        o_res_valid     = 1'b0;
        o_res           = '{kind: KIND_PAYLOAD, value: '0, reply_code: '0,
                            payload_length: '0};
        do_fail         = 1'b0;
        fail_echo       = i_byte;

        if (i_accept) begin
            if (!r_in_body) begin
                if (r_position == POS_W'(0)) begin
                    if (i_byte != i_cfg.sync_first) n_header_bad = 1'b1;
                    n_position = r_position + POS_W'(1);
                end else if (r_position == POS_W'(1)) begin
                    if (i_byte != i_cfg.sync_second) n_header_bad = 1'b1;
                    n_position = r_position + POS_W'(1);
                end else if (r_position == POS_W'(2)) begin
                    if (i_byte != want_third) n_header_bad = 1'b1;
                    n_position = r_position + POS_W'(1);
                end else if (r_header_bad || len_bad) begin
                    do_fail   = 1'b1;
                    fail_echo = i_byte;
                end else begin
                    n_error_count   = '0;
                    n_frame_length  = LEN_W'(i_byte);
                    n_in_body       = 1'b1;
                    n_position      = '0;
                    n_running_sum   = '0;
                    n_sum_high_byte = '0;
                end
            end else if (pos_ext < plen) begin
                n_running_sum = r_running_sum + SUM_W'(i_byte);
                n_position    = r_position + POS_W'(1);
                o_res_valid   = 1'b1;
                o_res.kind    = KIND_PAYLOAD;
                o_res.value   = i_byte;
            end else if (pos_ext == plen) begin
                n_sum_high_byte = i_byte;
                n_position      = r_position + POS_W'(1);
            end else if (sum_ok) begin
                n_error_count        = '0;
                o_res_valid          = 1'b1;
                o_res.kind           = KIND_ACK;
                o_res.value          = BYTE_W'(r_frame_length);
                o_res.reply_code     = i_cfg.ack_code;
                o_res.payload_length = PLEN_W'(plen);
                n_in_body            = 1'b0;
                n_position           = '0;
                n_header_bad         = 1'b0;
                n_running_sum        = '0;
                n_sum_high_byte      = '0;
            end else begin
                do_fail   = 1'b1;
                fail_echo = BYTE_W'(plen);
            end

            if (do_fail) begin
                o_res_valid = 1'b1;
                if (give_up) begin
                    n_error_count = '0;
                    o_res.kind    = KIND_GIVE_UP;
                end else begin
                    n_error_count    = err_next[BYTE_W-1:0];
                    o_res.kind       = KIND_NAK;
                    o_res.value      = fail_echo;
                    o_res.reply_code = i_cfg.nak_code;
                end
                n_in_body       = 1'b0;
                n_position      = '0;
                n_header_bad    = 1'b0;
                n_running_sum   = '0;
                n_sum_high_byte = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body       <= 1'b0;
            r_position      <= '0;
            r_header_bad    <= 1'b0;
            r_frame_length  <= '0;
            r_running_sum   <= '0;
            r_sum_high_byte <= '0;
            r_error_count   <= '0;
        end else begin
            r_in_body       <= n_in_body;
            r_position      <= n_position;
            r_header_bad    <= n_header_bad;
            r_frame_length  <= n_frame_length;
            r_running_sum   <= n_running_sum;
            r_sum_high_byte <= n_sum_high_byte;
            r_error_count   <= n_error_count;
        end
    end

endmodule

// ===== design/bfr_out_reg.sv =====
`timescale 1ns / 1ps

module bfr_out_reg import bfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_result   i_res,
    output logic      o_space,
    bfr_out_if.source o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_space = !r_valid || o_res.ready;
    assign n_valid = o_space ? i_res_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // load a new result only into a free or draining slot
    always_ff @(posedge i_clk) begin
        if (o_space && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.kind           = r_res.kind;
    assign o_res.value          = r_res.value;
    assign o_res.reply_code     = r_res.reply_code;
    assign o_res.payload_length = r_res.payload_length;

endmodule
